/* src/cpf_pkg.sv */
// cpf_pkg: shared types, codes and helpers of the csv row predicate filter
// depends on nothing; used by every module of the block
package cpf_pkg;

  localparam int unsigned DefGroups          = 7;
  localparam int unsigned DefFiltersPerGroup = 7;
  localparam int unsigned DefValueBytes      = 16;
  localparam int unsigned DefColumns         = 128;

  localparam int unsigned QueueDepth = 2;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned ColCfgW  = 7;
  localparam int unsigned CountW   = 32;

  localparam logic [7:0] CharComma   = 8'd44;
  localparam logic [7:0] CharNewline = 8'd10;

  typedef enum logic [2:0] {
    REG_GROUP_COUNT = 3'd0,
    REG_GROUP_SIZES = 3'd1,
    REG_SLOT        = 3'd2,
    REG_COLUMN      = 3'd3,
    REG_OPERATOR    = 3'd4,
    REG_VALUE_LEN   = 3'd5,
    REG_VALUE_LO    = 3'd6,
    REG_VALUE_HI    = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    OP_EQ = 3'd0,
    OP_NE = 3'd1,
    OP_GT = 3'd2,
    OP_LT = 3'd3,
    OP_GE = 3'd4,
    OP_LE = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_EQ = 2'd0,
    ST_LT = 2'd1,
    ST_GT = 2'd2
  } cmp_st_e;

  // work item handed from front to back
  typedef enum logic [1:0] {
    TK_FEED  = 2'd0,
    TK_CLOSE = 2'd1,
    TK_END   = 2'd2
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [7:0] data;
    logic       last;
  } token_t;

  function automatic logic op_holds(input logic [2:0] op, input cmp_st_e st);
    logic r;
    r = 1'b0;
    unique case (op)
      OP_EQ:   r = (st == ST_EQ);
      OP_NE:   r = (st != ST_EQ);
      OP_GT:   r = (st == ST_GT);
      OP_LT:   r = (st == ST_LT);
      OP_GE:   r = (st != ST_LT);
      OP_LE:   r = (st != ST_GT);
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* src/cpf_front.sv */
// cpf_front: takes text bytes and turns them into feed, close and end tokens
// depends on cpf_pkg
module cpf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_input_i,
  output logic              tok_valid_o,
  input  logic              tok_ready_i,
  output cpf_pkg::token_t   tok_o
);

  // pending end-of-line token after the last byte of a file
  logic pend_q, pend_d;
  logic in_acc;

  assign in_ready_o  = !pend_q && tok_ready_i;
  assign tok_valid_o = pend_q || in_valid_i;
  assign in_acc      = in_valid_i && in_ready_o;

  always_comb begin
    tok_o.data = data_byte_i;
    tok_o.last = end_of_input_i;
    tok_o.kind = cpf_pkg::TK_FEED;
    if (pend_q) begin
      tok_o.kind = cpf_pkg::TK_END;
      tok_o.last = 1'b1;
    end else if (data_byte_i == cpf_pkg::CharNewline) begin
      tok_o.kind = cpf_pkg::TK_END;
    end else if (data_byte_i == cpf_pkg::CharComma) begin
      tok_o.kind = cpf_pkg::TK_CLOSE;
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (pend_q && tok_ready_i) begin
      pend_d = 1'b0;
    end else if (in_acc && end_of_input_i && (data_byte_i != cpf_pkg::CharNewline)) begin
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
    end
  end

endmodule

/* src/cpf_queue.sv */
// cpf_queue: short token queue between front and back
// depends on cpf_pkg
module cpf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  cpf_pkg::token_t push_tok_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output cpf_pkg::token_t pop_tok_o
);

  localparam int unsigned Depth = cpf_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  cpf_pkg::token_t  mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_tok_o    = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_tok_i;
    end
  end

endmodule

/* src/cpf_back.sv */
// cpf_back: filter entries, per-entry compare lanes, row decision and result register
// depends on cpf_pkg
module cpf_back #(
  parameter int unsigned GROUPS            = cpf_pkg::DefGroups,
  parameter int unsigned FILTERS_PER_GROUP = cpf_pkg::DefFiltersPerGroup,
  parameter int unsigned VALUE_BYTES       = cpf_pkg::DefValueBytes,
  parameter int unsigned COLUMNS           = cpf_pkg::DefColumns
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cpf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cpf_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         tok_valid_i,
  output logic                         tok_ready_o,
  input  cpf_pkg::token_t              tok_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         row_match_o,
  output logic                         header_row_o,
  output logic [cpf_pkg::CountW-1:0]   matched_rows_o
);

  localparam int unsigned Entries = GROUPS * FILTERS_PER_GROUP;
  localparam int unsigned PosW    = $clog2(VALUE_BYTES + 1);
  localparam int unsigned BIdxW   = (VALUE_BYTES > 1) ? $clog2(VALUE_BYTES) : 1;
  localparam int unsigned ColW    = $clog2(COLUMNS + 1);

  // configuration
  logic [2:0]  group_count_q;
  logic [20:0] group_sizes_q;
  logic [5:0]  slot_q;

  logic [cpf_pkg::ColCfgW-1:0] col_q [Entries];
  logic [2:0]                  op_q  [Entries];
  logic [PosW-1:0]             len_q [Entries];
  logic [7:0]                  val_q [Entries][VALUE_BYTES];

  // line state
  logic [ColW-1:0]             colcnt_q, colcnt_d;
  logic [PosW-1:0]             pos_q, pos_d;
  cpf_pkg::cmp_st_e            st_q [Entries];
  cpf_pkg::cmp_st_e            st_d [Entries];
  logic [Entries-1:0]          hit_q, hit_d, hit_c;
  logic                        hdr_q, hdr_d;
  logic [cpf_pkg::CountW-1:0]  rows_q, rows_d;

  logic out_valid_q, match_q, header_q;
  logic do_tok, slot_free, is_end, row_ok;
  logic [PosW-1:0] len_w;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign is_end      = (tok_i.kind == cpf_pkg::TK_END);
  assign tok_ready_o = !is_end || slot_free;
  assign do_tok      = tok_valid_i && tok_ready_o;

  assign len_w = (32'(cfg_wdata_i[4:0]) > 32'(VALUE_BYTES)) ? PosW'(VALUE_BYTES)
                                                            : PosW'(cfg_wdata_i[4:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_count_q <= '0;
      group_sizes_q <= '0;
      slot_q        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cpf_pkg::REG_GROUP_COUNT: group_count_q <= cfg_wdata_i[2:0];
        cpf_pkg::REG_GROUP_SIZES: group_sizes_q <= cfg_wdata_i[20:0];
        cpf_pkg::REG_SLOT:        slot_q        <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  for (genvar e = 0; e < Entries; e++) begin : g_lane
    logic             sel;
    logic [7:0]       vbyte;
    cpf_pkg::cmp_st_e st_feed, st_fin;
    logic             col_hit;

    assign sel = cfg_we_i && (32'(slot_q) == e);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        col_q[e] <= '0;
        op_q[e]  <= '0;
        len_q[e] <= '0;
      end else if (sel) begin
        case (cfg_idx_i)
          cpf_pkg::REG_COLUMN:    col_q[e] <= cfg_wdata_i[cpf_pkg::ColCfgW-1:0];
          cpf_pkg::REG_OPERATOR:  op_q[e]  <= cfg_wdata_i[2:0];
          cpf_pkg::REG_VALUE_LEN: len_q[e] <= len_w;
          default: ;
        endcase
      end
    end

    for (genvar j = 0; j < VALUE_BYTES; j++) begin : g_byte
      if (j < 16) begin : g_w
        localparam cpf_pkg::reg_idx_e Reg = (j < 8) ? cpf_pkg::REG_VALUE_LO
                                                    : cpf_pkg::REG_VALUE_HI;
        localparam int unsigned Off = 8 * (j % 8);
        always_ff @(posedge clk_i or negedge rst_ni) begin
          if (!rst_ni) begin
            val_q[e][j] <= '0;
          end else if (sel && (cfg_idx_i == Reg)) begin
            val_q[e][j] <= cfg_wdata_i[Off +: 8];
          end
        end
      end else begin : g_z
        always_ff @(posedge clk_i or negedge rst_ni) begin
          if (!rst_ni) begin
            val_q[e][j] <= '0;
          end else begin
            val_q[e][j] <= '0;
          end
        end
      end
    end

    // byte compare on a feed, only while still equal
    assign vbyte = val_q[e][BIdxW'(pos_q)];
    always_comb begin
      st_feed = st_q[e];
      if (st_q[e] == cpf_pkg::ST_EQ) begin
        if (pos_q < len_q[e]) begin
          if (tok_i.data < vbyte) begin
            st_feed = cpf_pkg::ST_LT;
          end else if (tok_i.data > vbyte) begin
            st_feed = cpf_pkg::ST_GT;
          end
        end else begin
          st_feed = cpf_pkg::ST_GT;
        end
      end
    end

    // field close: a short field that matched so far is less
    assign st_fin  = ((st_q[e] == cpf_pkg::ST_EQ) && (pos_q < len_q[e])) ? cpf_pkg::ST_LT
                                                                         : st_q[e];
    assign col_hit = (32'(col_q[e]) == 32'(colcnt_q));
    assign hit_c[e] = col_hit ? cpf_pkg::op_holds(op_q[e], st_fin) : hit_q[e];

    always_comb begin
      st_d[e]  = st_q[e];
      hit_d[e] = hit_q[e];
      if (do_tok) begin
        case (tok_i.kind)
          cpf_pkg::TK_FEED: st_d[e] = st_feed;
          cpf_pkg::TK_CLOSE: begin
            st_d[e]  = cpf_pkg::ST_EQ;
            hit_d[e] = hit_c[e];
          end
          default: begin
            st_d[e]  = cpf_pkg::ST_EQ;
            hit_d[e] = 1'b0;
          end
        endcase
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[e]  <= cpf_pkg::ST_EQ;
        hit_q[e] <= 1'b0;
      end else begin
        st_q[e]  <= st_d[e];
        hit_q[e] <= hit_d[e];
      end
    end
  end

  // or over groups in use, where each group is the and of its filters in use
  logic [GROUPS-1:0] grp_ok;
  for (genvar g = 0; g < GROUPS; g++) begin : g_grp
    logic [2:0]                   size;
    logic [FILTERS_PER_GROUP-1:0] need;
    if (g < 7) begin : g_sz
      assign size = group_sizes_q[3*g +: 3];
    end else begin : g_nosz
      assign size = '0;
    end
    for (genvar i = 0; i < FILTERS_PER_GROUP; i++) begin : g_f
      assign need[i] = (32'(i) >= 32'(size)) || hit_c[g*FILTERS_PER_GROUP + i];
    end
    assign grp_ok[g] = (32'(g) < 32'(group_count_q)) && (&need);
  end
  assign row_ok = (group_count_q == '0) || (|grp_ok);

  always_comb begin
    colcnt_d = colcnt_q;
    pos_d    = pos_q;
    hdr_d    = hdr_q;
    rows_d   = rows_q;
    if (do_tok) begin
      case (tok_i.kind)
        cpf_pkg::TK_FEED: begin
          if (pos_q < PosW'(VALUE_BYTES)) begin
            pos_d = pos_q + 1'b1;
          end
        end
        cpf_pkg::TK_CLOSE: begin
          pos_d = '0;
          if (colcnt_q < ColW'(COLUMNS)) begin
            colcnt_d = colcnt_q + 1'b1;
          end
        end
        default: begin
          pos_d    = '0;
          colcnt_d = '0;
          hdr_d    = tok_i.last;
          if (!hdr_q && row_ok && (rows_q != '1)) begin
            rows_d = rows_q + 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colcnt_q    <= '0;
      pos_q       <= '0;
      hdr_q       <= 1'b1;
      rows_q      <= '0;
      out_valid_q <= 1'b0;
      match_q     <= 1'b0;
      header_q    <= 1'b0;
    end else begin
      colcnt_q <= colcnt_d;
      pos_q    <= pos_d;
      hdr_q    <= hdr_d;
      rows_q   <= rows_d;
      if (do_tok && is_end) begin
        out_valid_q <= 1'b1;
        match_q     <= hdr_q || row_ok;
        header_q    <= hdr_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign row_match_o    = match_q;
  assign header_row_o   = header_q;
  assign matched_rows_o = rows_q;

endmodule

/* src/csv_row_predicate_filter.sv */
// csv_row_predicate_filter: top level of the csv row filter
// depends on cpf_pkg, cpf_front, cpf_queue and cpf_back
//
// Streams csv text one byte per word and gives one result word per finished
// line: whether the row is kept, whether it was the header, and the saturating
// count of kept data rows. Every filter entry compares the incoming byte in
// parallel, so the block takes one byte per cycle while the queue has room;
// the front splits a last byte of a file that is not a newline into a field
// step and a line end, and takes no new byte until the line end is queued.
// A line end waits only for the result register to be free; a two-word queue
// between the classifying front and the compare back lets either side stall
// on its own. Configuration writes must be made while no line is in flight.
// After reset there is no clearing pass: all entries start at zero.
module csv_row_predicate_filter #(
  parameter int unsigned GROUPS            = cpf_pkg::DefGroups,
  parameter int unsigned FILTERS_PER_GROUP = cpf_pkg::DefFiltersPerGroup,
  parameter int unsigned VALUE_BYTES       = cpf_pkg::DefValueBytes,
  parameter int unsigned COLUMNS           = cpf_pkg::DefColumns
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration writes
  input  logic                         cfg_we_i,
  input  logic [cpf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cpf_pkg::CfgDataW-1:0] cfg_wdata_i,
  // text byte words
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   data_byte_i,
  input  logic                         end_of_input_i,
  // row result words
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         row_match_o,
  output logic                         header_row_o,
  output logic [cpf_pkg::CountW-1:0]   matched_rows_o
);

  // front to queue
  logic            f_valid, f_ready;
  cpf_pkg::token_t f_tok;
  // queue to back
  logic            b_valid, b_ready;
  cpf_pkg::token_t b_tok;

  // byte classification: data, field separator or line end
  cpf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_input_i (end_of_input_i),
    .tok_valid_o    (f_valid),
    .tok_ready_i    (f_ready),
    .tok_o          (f_tok)
  );

  // decoupling queue
  cpf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_tok_i   (f_tok),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_tok_o    (b_tok)
  );

  // compare lanes, row decision and result register
  cpf_back #(
    .GROUPS            (GROUPS),
    .FILTERS_PER_GROUP (FILTERS_PER_GROUP),
    .VALUE_BYTES       (VALUE_BYTES),
    .COLUMNS           (COLUMNS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .tok_valid_i    (b_valid),
    .tok_ready_o    (b_ready),
    .tok_i          (b_tok),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .row_match_o    (row_match_o),
    .header_row_o   (header_row_o),
    .matched_rows_o (matched_rows_o)
  );

endmodule

/* tb/csv_row_predicate_filter_tb.sv */
// csv_row_predicate_filter_tb: self-checking bench for the csv row predicate filter
// depends on cpf_pkg and csv_row_predicate_filter; streams csv text and checks each
// line result against a behavioral predictor of the filter
module csv_row_predicate_filter_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NGRP = 7;
  localparam int NFLT = 7;
  localparam int NENT = NGRP * NFLT;
  localparam int NVB = 16;
  localparam int NCOL = 128;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic        keep;
    logic        hdr;
    logic [31:0] count;
  } row_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [cpf_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [cpf_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [7:0] data_byte_i = '0;
  logic end_of_input_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic row_match_o;
  logic header_row_o;
  logic [31:0] matched_rows_o;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  csv_row_predicate_filter dut (.*);

  // predictor state: configuration shadow and line progress
  logic [2:0]  m_grp_count;
  logic [20:0] m_grp_sizes;
  logic [5:0]  m_slot;
  logic [6:0]  m_col [NENT];
  logic [2:0]  m_op [NENT];
  logic [4:0]  m_len [NENT];
  logic [7:0]  m_val [NENT][NVB];
  cpf_pkg::cmp_st_e m_st [NENT];
  logic        m_hit [NENT];
  int unsigned m_colnum, m_pos;
  logic        m_at_hdr;
  logic [31:0] m_rows;

  row_res_t expected_rows[$];
  int n_err = 0;
  int idle_cycles = 0;

  // randomized gap / stall shaping
  int gap_max = 4;
  int stall_pct = 30;

  function automatic logic op_true(logic [2:0] op, cpf_pkg::cmp_st_e st);
    case (op)
      cpf_pkg::OP_EQ: return st == cpf_pkg::ST_EQ;
      cpf_pkg::OP_NE: return st != cpf_pkg::ST_EQ;
      cpf_pkg::OP_GT: return st == cpf_pkg::ST_GT;
      cpf_pkg::OP_LT: return st == cpf_pkg::ST_LT;
      cpf_pkg::OP_GE: return st != cpf_pkg::ST_LT;
      cpf_pkg::OP_LE: return st != cpf_pkg::ST_GT;
      default: return 1'b0;
    endcase
  endfunction

  task automatic model_clear();
    m_grp_count = '0; m_grp_sizes = '0; m_slot = '0;
    for (int e = 0; e < NENT; e++) begin
      m_col[e] = '0; m_op[e] = '0; m_len[e] = '0;
      m_st[e] = cpf_pkg::ST_EQ; m_hit[e] = 1'b0;
      for (int k = 0; k < NVB; k++) m_val[e][k] = '0;
    end
    m_colnum = 0; m_pos = 0; m_at_hdr = 1'b1; m_rows = '0;
  endtask

  task automatic model_write(cpf_pkg::reg_idx_e idx, logic [63:0] v);
    bit ok;
    ok = m_slot < NENT;
    case (idx)
      cpf_pkg::REG_GROUP_COUNT: m_grp_count = v[2:0];
      cpf_pkg::REG_GROUP_SIZES: m_grp_sizes = v[20:0];
      cpf_pkg::REG_SLOT:        m_slot = v[5:0];
      cpf_pkg::REG_COLUMN:      if (ok) m_col[m_slot] = v[6:0];
      cpf_pkg::REG_OPERATOR:    if (ok) m_op[m_slot] = v[2:0];
      cpf_pkg::REG_VALUE_LEN:   if (ok) m_len[m_slot] = (v[4:0] > NVB) ? 5'(NVB) : v[4:0];
      cpf_pkg::REG_VALUE_LO:
        if (ok) for (int k = 0; k < 8; k++) m_val[m_slot][k] = v[8*k +: 8];
      cpf_pkg::REG_VALUE_HI:
        if (ok) for (int k = 0; k < 8; k++) m_val[m_slot][8+k] = v[8*k +: 8];
      default: ;
    endcase
  endtask

  task automatic model_feed(logic [7:0] b);
    for (int e = 0; e < NENT; e++)
      if (m_st[e] == cpf_pkg::ST_EQ) begin
        if (m_pos < m_len[e]) begin
          if (b < m_val[e][m_pos]) m_st[e] = cpf_pkg::ST_LT;
          else if (b > m_val[e][m_pos]) m_st[e] = cpf_pkg::ST_GT;
        end else m_st[e] = cpf_pkg::ST_GT;
      end
    if (m_pos < NVB) m_pos++;
  endtask

  task automatic model_close_field();
    cpf_pkg::cmp_st_e st;
    for (int e = 0; e < NENT; e++) begin
      if (m_col[e] == m_colnum) begin
        st = m_st[e];
        if (st == cpf_pkg::ST_EQ && m_pos < m_len[e]) st = cpf_pkg::ST_LT;
        m_hit[e] = op_true(m_op[e], st);
      end
      m_st[e] = cpf_pkg::ST_EQ;
    end
    m_pos = 0;
    if (m_colnum < NCOL) m_colnum++;
  endtask

  task automatic model_end_line(bit last);
    row_res_t r;
    bit any, all;
    int sz;
    r.hdr = m_at_hdr;
    if (m_at_hdr) r.keep = 1'b1;
    else begin
      any = (m_grp_count == 0);
      for (int g = 0; g < m_grp_count; g++) begin
        sz = m_grp_sizes[3*g +: 3];
        all = 1;
        for (int i = 0; i < sz; i++) if (!m_hit[g*NFLT+i]) all = 0;
        if (all) any = 1;
      end
      r.keep = any;
      if (any && m_rows != 32'hFFFF_FFFF) m_rows++;
    end
    r.count = m_rows;
    expected_rows.push_back(r);
    m_colnum = 0; m_pos = 0;
    for (int e = 0; e < NENT; e++) begin m_st[e] = cpf_pkg::ST_EQ; m_hit[e] = 1'b0; end
    m_at_hdr = last;
  endtask

  // predicts the results caused by one accepted text byte
  task automatic model_byte(logic [7:0] b, logic last);
    if (b == cpf_pkg::CharNewline) begin
      model_close_field(); model_end_line(last);
    end else if (b == cpf_pkg::CharComma) begin
      model_close_field();
      if (last) begin model_close_field(); model_end_line(1'b1); end
    end else begin
      model_feed(b);
      if (last) begin model_close_field(); model_end_line(1'b1); end
    end
  endtask

  // send one text byte, with a random gap in front of it; valid stays up
  // between back to back words and is dropped by a gap or by drain
  task automatic send_byte(logic [7:0] b, logic last = 1'b0);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, gap_max) : 0;
    cfg_we_i <= 1'b0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    end_of_input_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    model_byte(b, last);
  endtask

  task automatic send_text(string s, bit last_mark = 0);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], last_mark && i == s.len() - 1);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    cfg_we_i <= 1'b0;
    while (expected_rows.size() != 0 && guard < IDLE_LIMIT) begin
      @(posedge clk_i); guard++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  // one register write; the enable is dropped by the next send or drain
  task automatic reg_write(cpf_pkg::reg_idx_e idx, logic [63:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    model_write(idx, v);
  endtask

  // program one filter entry; value string given as up to 16 bytes
  task automatic set_filter(int slot, int col, logic [2:0] op, int len,
                            logic [63:0] lo, logic [63:0] hi);
    reg_write(cpf_pkg::REG_SLOT, 64'(slot));
    reg_write(cpf_pkg::REG_COLUMN, 64'(col));
    reg_write(cpf_pkg::REG_OPERATOR, 64'(op));
    reg_write(cpf_pkg::REG_VALUE_LEN, 64'(len));
    reg_write(cpf_pkg::REG_VALUE_LO, lo);
    reg_write(cpf_pkg::REG_VALUE_HI, hi);
  endtask

  // result checker: receiver stalls on its own pattern
  always @(posedge clk_i) begin
    row_res_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_rows.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected row result keep=%0b", row_match_o);
        end else begin
          exp_r = expected_rows.pop_front();
          if (exp_r.keep !== row_match_o || exp_r.hdr !== header_row_o
              || exp_r.count !== matched_rows_o) begin
            n_err++;
            if (n_err <= 10)
              $display("row mismatch: exp keep=%0b hdr=%0b cnt=%0d got %0b %0b %0d",
                       exp_r.keep, exp_r.hdr, exp_r.count,
                       row_match_o, header_row_o, matched_rows_o);
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // watchdog on accepted words
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i
        || (expected_rows.size() == 0 && !in_valid_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // header handling, default all-pass and end-of-input variants
  task automatic test_passthrough();
    send_text("a,b\n1,2\n,\n");
    send_text("x,", 1);
    send_text("h\nq", 1);
    send_byte(8'h00); send_byte(8'hFF); send_byte(cpf_pkg::CharNewline, 1'b1);
    drain();
  endtask

  // each operator against short strings, missing column, zero and 255 bytes
  task automatic test_operators();
    reg_write(cpf_pkg::REG_GROUP_COUNT, 64'd6);
    reg_write(cpf_pkg::REG_GROUP_SIZES,
              64'({3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1}));
    for (int g = 0; g < 6; g++) set_filter(g*NFLT, 1, 3'(g), 2, 64'h4d4d, 64'd0);
    set_filter(NENT - 1, 127, cpf_pkg::OP_EQ, 16, '1, '1);
    reg_write(cpf_pkg::REG_SLOT, 64'd63); reg_write(cpf_pkg::REG_COLUMN, 64'd5); // ignored slot
    send_text("h\n");
    send_text("z,MM\n"); send_text("z,MN\n"); send_text("z,M\n");
    send_text("z,MMM\n"); send_text("z,ML\n"); send_text("z\n");
    send_text("z,\n");
    send_byte(8'h00); send_byte(cpf_pkg::CharComma); send_byte(8'hFF);
    send_byte(cpf_pkg::CharNewline);
    drain();
  endtask

  task automatic rand_config();
    int ng;
    ng = $urandom_range(0, 7);
    reg_write(cpf_pkg::REG_GROUP_COUNT, 64'(ng));
    reg_write(cpf_pkg::REG_GROUP_SIZES,
              64'($urandom_range(0, 21'h1FFFFF) & ($urandom_range(0,1) ?
                  21'h1FFFFF : 21'h092492)));
    for (int e = 0; e < NENT; e++) begin
      if ($urandom_range(0, 3) == 0) continue;
      set_filter(e, $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(0, 127),
                 3'($urandom_range(0, 7)), $urandom_range(0, 31),
                 {8'($urandom_range(48,50)), 8'($urandom_range(48,50)),
                  8'($urandom_range(48,50)), 8'($urandom),
                  8'($urandom_range(48,50)), 8'($urandom_range(48,50)),
                  8'($urandom_range(48,50)), 8'($urandom_range(48,50))},
                 {$urandom, $urandom});
    end
  endtask

  // mostly small-alphabet csv lines so string compares often hit equality
  task automatic rand_text(int nbytes);
    logic [7:0] b;
    int r;
    for (int i = 0; i < nbytes; i++) begin
      r = $urandom_range(0, 99);
      if (r < 12) b = cpf_pkg::CharComma;
      else if (r < 20) b = cpf_pkg::CharNewline;
      else if (r < 85) b = 8'($urandom_range(48, 50));
      else b = 8'($urandom_range(0, 255));
      send_byte(b, $urandom_range(0, 99) == 0);
    end
    send_byte(cpf_pkg::CharNewline);
  endtask

  task automatic test_random();
    for (int p = 0; p < 8; p++) begin
      gap_max = (p % 3 == 0) ? 0 : $urandom_range(1, 8);
      stall_pct = (p % 4 == 0) ? 0 : $urandom_range(10, 70);
      rand_config();
      rand_text(190);
      drain();
    end
  endtask

  // many columns and very long fields
  task automatic test_long_lines();
    set_filter(0, 127, cpf_pkg::OP_GE, 16, 64'h3030303030303030, 64'h3030303030303030);
    reg_write(cpf_pkg::REG_GROUP_COUNT, 64'd1);
    reg_write(cpf_pkg::REG_GROUP_SIZES, 64'd1);
    for (int c = 0; c < 135; c++) send_byte(cpf_pkg::CharComma);
    send_byte(cpf_pkg::CharNewline);
    repeat (40) send_byte(8'h31);
    send_byte(cpf_pkg::CharNewline);
    drain();
  endtask

  initial begin
    model_clear();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_passthrough();
    test_operators();
    test_long_lines();
    test_random();
    drain();
    if (n_err == 0 && expected_rows.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
